// ===== src/ufe_pkg.sv =====
// Shared types and constants for the union-find edge filter.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ufe_pkg;

  localparam int ID_W   = 10;  // vertex id and root fields
  localparam int CFG_W  = 11;  // vertex_count register
  localparam int WT_W   = 16;  // edge weight port
  localparam int SUM_W  = 40;  // saturating weight total
  localparam int SKIP_W = 22;  // saturating excluded-edge count

  localparam logic [CFG_W-1:0] VCOUNT_RESET = 11'd1024;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_COMP,
    S_MERGE
  } ufe_state_t;

  // One finished edge, handed from the sequencer to the totals unit.
  typedef struct packed {
    logic            valid;
    logic            id_error;
    logic            taken;
    logic            fin;
    logic [1:0]      big;     // number of merged roots that already held edges
    logic [ID_W-1:0] keep;
    logic [ID_W-1:0] gone;
    logic [WT_W-1:0] weight;
  } ufe_evt_t;

endpackage

`default_nettype wire

// ===== src/ufe_mem.sv =====
// Parent and rank memories of the union-find forest, with registered read data.
// Depends on ufe_pkg; a write to the entry being read is forwarded.
`timescale 1ns / 1ps
`default_nettype none

module ufe_mem
  import ufe_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int RW    = 4
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [AW-1:0] par_q,
  output logic      [RW-1:0] rk_q,
  input  wire logic          par_we,
  input  wire logic [AW-1:0] par_waddr,
  input  wire logic [AW-1:0] par_wdata,
  input  wire logic          rk_we,
  input  wire logic [AW-1:0] rk_waddr,
  input  wire logic [RW-1:0] rk_wdata
);

  logic [AW-1:0] par_mem [DEPTH];
  logic [RW-1:0] rk_mem  [DEPTH];
  logic [AW-1:0] par_q_r;
  logic [RW-1:0] rk_q_r;

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    if (par_we && (par_waddr == rd_addr)) begin
      par_q_r <= par_wdata;
    end else begin
      par_q_r <= par_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rk_we) begin
      rk_mem[rk_waddr] <= rk_wdata;
    end
    if (rk_we && (rk_waddr == rd_addr)) begin
      rk_q_r <= rk_wdata;
    end else begin
      rk_q_r <= rk_mem[rd_addr];
    end
  end

  assign par_q = par_q_r;
  assign rk_q  = rk_q_r;

endmodule

`default_nettype wire

// ===== src/ufe_ctrl.sv =====
// Sequencer: range check, root walks, path compression, union and clearing.
// Depends on ufe_pkg; drives the ports of ufe_mem and hands events to ufe_acc.
`timescale 1ns / 1ps
`default_nettype none

module ufe_ctrl
  import ufe_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int AW           = 10,
  parameter int RW           = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [ID_W-1:0]  in_vertex_a,
  input  wire logic [ID_W-1:0]  in_vertex_b,
  input  wire logic [WT_W-1:0]  in_edge_weight,
  input  wire logic             in_final_edge,
  input  wire logic [CFG_W-1:0] vertex_count,
  output logic      [AW-1:0]    rd_addr,
  input  wire logic [AW-1:0]    par_q,
  input  wire logic [RW-1:0]    rk_q,
  output logic                  par_we,
  output logic      [AW-1:0]    par_waddr,
  output logic      [AW-1:0]    par_wdata,
  output logic                  rk_we,
  output logic      [AW-1:0]    rk_waddr,
  output logic      [RW-1:0]    rk_wdata,
  output ufe_evt_t              evt
);

  localparam int CMPW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
  localparam logic [CMPW-1:0] VMAX     = CMPW'(MAX_VERTICES);
  localparam logic [AW-1:0]   LAST_IDX = AW'(MAX_VERTICES - 1);

  ufe_state_t      state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [AW-1:0]   cur_r, cur_nxt;
  logic [AW-1:0]   start_r, start_nxt;
  logic [AW-1:0]   b_r, b_nxt;
  logic [AW-1:0]   root_a_r, root_a_nxt;
  logic [RW-1:0]   rank_a_r, rank_a_nxt;
  logic [AW-1:0]   root_b_r, root_b_nxt;
  logic [RW-1:0]   rank_b_r, rank_b_nxt;
  logic            deep_r, deep_nxt;
  logic            phase_b_r, phase_b_nxt;
  logic            fin_r, fin_nxt;
  logic [WT_W-1:0] weight_r, weight_nxt;

  logic [CMPW-1:0] limit;
  logic            id_bad;
  logic [AW-1:0]   mg_rb;
  logic [RW-1:0]   mg_kb;
  logic [AW-1:0]   comp_root;
  logic            go_b;
  logic            do_merge;

  always_comb begin
    limit  = (CMPW'(vertex_count) > VMAX) ? VMAX : CMPW'(vertex_count);
    id_bad = (CMPW'(in_vertex_a) >= limit) || (CMPW'(in_vertex_b) >= limit);
  end

  // The merge happens either straight from the read data of b's root or,
  // after b's path was compressed, from the saved root.
  assign mg_rb     = (state_r == S_MERGE) ? root_b_r : cur_r;
  assign mg_kb     = (state_r == S_MERGE) ? rank_b_r : rk_q;
  assign comp_root = phase_b_r ? root_b_r : root_a_r;
  assign busy      = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    start_r   <= start_nxt;
    b_r       <= b_nxt;
    root_a_r  <= root_a_nxt;
    rank_a_r  <= rank_a_nxt;
    root_b_r  <= root_b_nxt;
    rank_b_r  <= rank_b_nxt;
    deep_r    <= deep_nxt;
    phase_b_r <= phase_b_nxt;
    fin_r     <= fin_nxt;
    weight_r  <= weight_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    cur_nxt     = cur_r;
    start_nxt   = start_r;
    b_nxt       = b_r;
    root_a_nxt  = root_a_r;
    rank_a_nxt  = rank_a_r;
    root_b_nxt  = root_b_r;
    rank_b_nxt  = rank_b_r;
    deep_nxt    = deep_r;
    phase_b_nxt = phase_b_r;
    fin_nxt     = fin_r;
    weight_nxt  = weight_r;
    rd_addr     = cur_r;
    par_we      = 1'b0;
    par_waddr   = cur_r;
    par_wdata   = comp_root;
    rk_we       = 1'b0;
    rk_waddr    = mg_rb;
    rk_wdata    = '0;
    evt         = '0;
    go_b        = 1'b0;
    do_merge    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        par_we    = 1'b1;
        par_waddr = clr_r;
        par_wdata = clr_r;
        rk_we     = 1'b1;
        rk_waddr  = clr_r;
        rk_wdata  = '0;
        if (clr_r == LAST_IDX) begin
          clr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          fin_nxt    = in_final_edge;
          weight_nxt = in_edge_weight;
          if (id_bad) begin
            evt.valid    = 1'b1;
            evt.id_error = 1'b1;
            evt.fin      = in_final_edge;
            evt.weight   = in_edge_weight;
            state_nxt    = in_final_edge ? S_CLEAR : S_IDLE;
          end else begin
            cur_nxt     = AW'(in_vertex_a);
            start_nxt   = AW'(in_vertex_a);
            b_nxt       = AW'(in_vertex_b);
            rd_addr     = AW'(in_vertex_a);
            deep_nxt    = 1'b0;
            phase_b_nxt = 1'b0;
            state_nxt   = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (par_q == cur_r) begin
          if (!phase_b_r) begin
            root_a_nxt = cur_r;
            rank_a_nxt = rk_q;
          end else begin
            root_b_nxt = cur_r;
            rank_b_nxt = rk_q;
          end
          if (deep_r) begin
            cur_nxt   = start_r;
            rd_addr   = start_r;
            state_nxt = S_COMP;
          end else if (!phase_b_r) begin
            go_b = 1'b1;
          end else begin
            do_merge = 1'b1;
          end
        end else begin
          // A second hop means the start node does not hang off its root.
          deep_nxt = deep_r | (cur_r != start_r);
          cur_nxt  = par_q;
          rd_addr  = par_q;
        end
      end
      S_COMP: begin
        if (par_q == comp_root) begin
          if (!phase_b_r) begin
            go_b = 1'b1;
          end else begin
            state_nxt = S_MERGE;
          end
        end else begin
          par_we    = 1'b1;
          par_waddr = cur_r;
          par_wdata = comp_root;
          cur_nxt   = par_q;
          rd_addr   = par_q;
        end
      end
      S_MERGE: begin
        do_merge = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (go_b) begin
      cur_nxt     = b_r;
      start_nxt   = b_r;
      rd_addr     = b_r;
      deep_nxt    = 1'b0;
      phase_b_nxt = 1'b1;
      state_nxt   = S_WALK;
    end

    if (do_merge) begin
      evt.valid  = 1'b1;
      evt.fin    = fin_r;
      evt.weight = weight_r;
      evt.big    = {1'b0, (rank_a_r != '0)} + {1'b0, (mg_kb != '0)};
      if (root_a_r == mg_rb) begin
        evt.keep = ID_W'(root_a_r);
        evt.gone = ID_W'(root_a_r);
      end else if (rank_a_r > mg_kb) begin
        par_we    = 1'b1;
        par_waddr = mg_rb;
        par_wdata = root_a_r;
        evt.taken = 1'b1;
        evt.keep  = ID_W'(root_a_r);
        evt.gone  = ID_W'(mg_rb);
      end else begin
        par_we    = 1'b1;
        par_waddr = root_a_r;
        par_wdata = mg_rb;
        if (rank_a_r == mg_kb) begin
          rk_we    = 1'b1;
          rk_waddr = mg_rb;
          rk_wdata = mg_kb + RW'(1);
        end
        evt.taken = 1'b1;
        evt.keep  = ID_W'(mg_rb);
        evt.gone  = ID_W'(root_a_r);
      end
      state_nxt = fin_r ? S_CLEAR : S_IDLE;
    end
  end

  a_comp_no_self_read: assert property (@(posedge clk) disable iff (!rst_n)
    par_we && (state_r == S_COMP) |-> par_waddr != rd_addr)
    else $error("compression writes the node it reads");

  a_merge_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    evt.valid && evt.taken |-> evt.keep != evt.gone)
    else $error("merge of a root with itself");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    evt.valid && evt.fin |=> state_r == S_CLEAR)
    else $error("final edge did not start the clearing pass");

endmodule

`default_nettype wire

// ===== src/ufe_acc.sv =====
// Totals and result registers: weight sum, excluded count, tree count, root.
// Depends on ufe_pkg; takes one event per finished edge from ufe_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ufe_acc
  import ufe_pkg::*;
#(
  parameter int AW          = 10,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire ufe_evt_t evt_i,
  output logic              out_valid,
  output logic              out_taken,
  output logic [ID_W-1:0]   out_surviving_root,
  output logic [ID_W-1:0]   out_absorbed_root,
  output logic [SUM_W-1:0]  out_weight_total,
  output logic [SKIP_W-1:0] out_skipped_total,
  output logic [ID_W-1:0]   out_tree_root,
  output logic              out_id_error,
  output logic              out_run_end
);

  localparam int WB  = (WEIGHT_BITS < WT_W) ? WEIGHT_BITS : WT_W;
  localparam int TCW = AW + 1;

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SKIP_W-1:0] skip_r, skip_nxt;
  logic [TCW-1:0]    trees_r, trees_nxt;
  logic [ID_W-1:0]   last_keep_r, last_keep_nxt;

  logic              out_valid_r;
  logic              out_taken_r;
  logic [ID_W-1:0]   out_keep_r;
  logic [ID_W-1:0]   out_gone_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic [SKIP_W-1:0] out_skip_r;
  logic [ID_W-1:0]   out_troot_r;
  logic              out_err_r;
  logic              out_run_end_r;

  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_upd;
  logic [SKIP_W-1:0] skip_upd;
  logic [TCW-1:0]    trees_upd;
  logic [ID_W-1:0]   keep_upd;
  logic [ID_W-1:0]   troot;

  always_comb begin
    sum_add   = {1'b0, sum_r} + (SUM_W + 1)'(evt_i.weight[WB-1:0]);
    sum_upd   = sum_r;
    skip_upd  = skip_r;
    trees_upd = trees_r;
    keep_upd  = last_keep_r;
    if (evt_i.taken) begin
      sum_upd   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      trees_upd = trees_r + TCW'(1) - TCW'(evt_i.big);
      keep_upd  = evt_i.keep;
    end else if (!evt_i.id_error && (skip_r != '1)) begin
      skip_upd = skip_r + SKIP_W'(1);
    end
    // With exactly one tree left, the root of the latest merge is its root.
    troot = (evt_i.fin && (trees_upd == TCW'(1))) ? keep_upd : '0;

    sum_nxt       = sum_r;
    skip_nxt      = skip_r;
    trees_nxt     = trees_r;
    last_keep_nxt = last_keep_r;
    if (evt_i.valid) begin
      if (evt_i.fin) begin
        sum_nxt   = '0;
        skip_nxt  = '0;
        trees_nxt = '0;
      end else begin
        sum_nxt   = sum_upd;
        skip_nxt  = skip_upd;
        trees_nxt = trees_upd;
      end
      last_keep_nxt = keep_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      skip_r      <= '0;
      trees_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      skip_r      <= skip_nxt;
      trees_r     <= trees_nxt;
      out_valid_r <= evt_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    last_keep_r <= last_keep_nxt;
    if (evt_i.valid) begin
      out_taken_r   <= evt_i.taken;
      out_keep_r    <= evt_i.keep;
      out_gone_r    <= evt_i.gone;
      out_sum_r     <= sum_upd;
      out_skip_r    <= skip_upd;
      out_troot_r   <= troot;
      out_err_r     <= evt_i.id_error;
      out_run_end_r <= evt_i.fin;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_taken          = out_taken_r;
  assign out_surviving_root = out_keep_r;
  assign out_absorbed_root  = out_gone_r;
  assign out_weight_total   = out_sum_r;
  assign out_skipped_total  = out_skip_r;
  assign out_tree_root      = out_troot_r;
  assign out_id_error       = out_err_r;
  assign out_run_end        = out_run_end_r;

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    evt_i.valid |=> out_valid_r)
    else $error("finished edge produced no result strobe");

  a_strobe_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(evt_i.valid))
    else $error("result strobe without a finished edge");

endmodule

`default_nettype wire

// ===== src/kruskal_union_find_edge_filter_top.sv =====
// Top level of the Kruskal edge filter over a union-find forest.
// Depends on ufe_pkg, ufe_mem, ufe_ctrl and ufe_acc.
`timescale 1ns / 1ps
`default_nettype none

// An accepted edge walks a to its root, then b; a path more than one hop deep is compressed
// right after its walk, and the union follows b's walk or, after b's compression, S_MERGE.
// The result is registered in ufe_acc. A new edge is accepted only in idle, after the last
// edge's event, since every hop goes through the single memory read port; a flagged edge
// finishes at acceptance and strobes in the next cycle. The receiver cannot stall.
// Reset and every final edge start a clear of all MAX_VERTICES entries.
module kruskal_union_find_edge_filter_top
  import ufe_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ID_W-1:0]   in_vertex_a,
  input  wire logic [ID_W-1:0]   in_vertex_b,
  input  wire logic [WT_W-1:0]   in_edge_weight,
  input  wire logic              in_final_edge,
  output logic                   out_valid,
  output logic                   out_taken,
  output logic      [ID_W-1:0]   out_surviving_root,
  output logic      [ID_W-1:0]   out_absorbed_root,
  output logic      [SUM_W-1:0]  out_weight_total,
  output logic      [SKIP_W-1:0] out_skipped_total,
  output logic      [ID_W-1:0]   out_tree_root,
  output logic                   out_id_error,
  output logic                   out_run_end,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_vertex_count
);

  // Vertex ids inside the forest are just wide enough for MAX_VERTICES entries.
  // Ranks never exceed the log of the vertex count, so a few bits hold them.
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int RW = $clog2(AW + 1);

  logic [CFG_W-1:0] vertex_count_r;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] par_q;
  logic [RW-1:0] rk_q;
  logic          par_we;
  logic [AW-1:0] par_waddr;
  logic [AW-1:0] par_wdata;
  logic          rk_we;
  logic [AW-1:0] rk_waddr;
  logic [RW-1:0] rk_wdata;
  ufe_evt_t      evt;

  // The vertex count register can be written at any time, including during the
  // clearing pass. It is only sampled when an edge is accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VCOUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count_r <= cfg_vertex_count;
    end
  end

  // Parent pointers and ranks live in two memories read at one shared address.
  ufe_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW),
    .RW    (RW)
  ) u_mem (
    .clk       (clk),
    .rd_addr   (rd_addr),
    .par_q     (par_q),
    .rk_q      (rk_q),
    .par_we    (par_we),
    .par_waddr (par_waddr),
    .par_wdata (par_wdata),
    .rk_we     (rk_we),
    .rk_waddr  (rk_waddr),
    .rk_wdata  (rk_wdata)
  );

  // The sequencer walks both endpoints to their roots, compresses the walked
  // paths when they are more than one hop deep, and performs the union by rank.
  ufe_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW),
    .RW           (RW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_vertex_a    (in_vertex_a),
    .in_vertex_b    (in_vertex_b),
    .in_edge_weight (in_edge_weight),
    .in_final_edge  (in_final_edge),
    .vertex_count   (vertex_count_r),
    .rd_addr        (rd_addr),
    .par_q          (par_q),
    .rk_q           (rk_q),
    .par_we         (par_we),
    .par_waddr      (par_waddr),
    .par_wdata      (par_wdata),
    .rk_we          (rk_we),
    .rk_waddr       (rk_waddr),
    .rk_wdata       (rk_wdata),
    .evt            (evt)
  );

  // Running totals and the registered result item. The single tree's root on a
  // final edge comes from the tree count and the most recent surviving root.
  ufe_acc #(
    .AW          (AW),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_acc (
    .clk                (clk),
    .rst_n              (rst_n),
    .evt_i              (evt),
    .out_valid          (out_valid),
    .out_taken          (out_taken),
    .out_surviving_root (out_surviving_root),
    .out_absorbed_root  (out_absorbed_root),
    .out_weight_total   (out_weight_total),
    .out_skipped_total  (out_skipped_total),
    .out_tree_root      (out_tree_root),
    .out_id_error       (out_id_error),
    .out_run_end        (out_run_end)
  );

endmodule

`default_nettype wire
